// ===== design/ssb_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ssb_pkg
// Shared types, constants and ordering functions for the sprite sort batcher.
// ============================================================================
package ssb_pkg;

    // Capacity and fixed field widths.
    localparam int MAX_GLYPHS_DEF = 64;
    localparam int IDX_W          = 6;
    localparam int TEX_W          = 32;
    localparam int DEPTH_W        = 32;
    localparam int VTX_W          = 9;
    localparam int MODE_W         = 2;
    localparam logic [VTX_W-1:0] VERTS_PER_GLYPH = VTX_W'(6);

    // Sort mode codes.
    localparam logic [MODE_W-1:0] MODE_DEPTH_DESC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEPTH_ASC  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TEXTURE    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED     = 2'd3;
    localparam logic [MODE_W-1:0] MODE_RESET      = MODE_TEXTURE;

    // Input beat.
    typedef struct packed {
        logic [TEX_W-1:0]   texture_id;
        logic [DEPTH_W-1:0] depth_bits;
        logic               last_sprite;
    } t_sprite;

    // Result beat.
    typedef struct packed {
        logic [IDX_W-1:0] sprite_index;
        logic [TEX_W-1:0] texture_out;
        logic [VTX_W-1:0] vertex_offset;
        logic             batch_start;
        logic [VTX_W-1:0] batch_vertex_count;
        logic             overflow;
        logic             last_result;
    } t_result;

    // One stored sprite as it moves along the cell chain.
    typedef struct packed {
        logic [TEX_W-1:0]   texture;
        logic [DEPTH_W-1:0] depth;
        logic [IDX_W-1:0]   index;
    } t_entry;

    // Controls broadcast to every cell.
    typedef struct packed {
        logic              shift;
        logic              sort;
        logic              phase;
        logic [MODE_W-1:0] mode;
    } t_cell_ctl;

    // Controls for the result formatter.
    typedef struct packed {
        logic active;
        logic overflow;
    } t_emit_ctl;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SORT,
        S_EMIT
    } t_state;

    // Map a raw IEEE single onto an unsigned total order.
    function automatic logic [DEPTH_W-1:0] depth_key(input logic [DEPTH_W-1:0] bits);
        logic [DEPTH_W-1:0] key;
        if (bits[DEPTH_W-1]) begin
            key = ~bits;
        end else begin
            key = bits | {1'b1, {(DEPTH_W-1){1'b0}}};
        end
        return key;
    endfunction

    // True when sprite a must be placed strictly before sprite b.
    function automatic logic goes_before(input logic [MODE_W-1:0] mode,
                                         input t_entry a, input t_entry b);
        logic res;
        unique case (mode)
            MODE_DEPTH_DESC: res = depth_key(a.depth) > depth_key(b.depth);
            MODE_DEPTH_ASC:  res = depth_key(a.depth) < depth_key(b.depth);
            MODE_TEXTURE:    res = a.texture < b.texture;
            MODE_UNUSED:     res = 1'b0;
            default:         res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

// ===== design/ssb_cell.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ssb_cell
// One slot of the sorting chain: shifts sprites down while loading and
// emitting, and does odd-even compare-exchange with its neighbors while
// sorting.
// ============================================================================
module ssb_cell
    import ssb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_odd,
    input  logic      i_up_valid,
    input  t_entry    i_up_entry,
    input  logic      i_dn_swap,
    input  t_entry    i_dn_entry,
    output logic      o_valid,
    output t_entry    o_entry,
    output logic      o_swap_up
);

    logic   r_valid;
    t_entry r_entry;
    logic   n_valid;
    t_entry n_entry;

    // This cell is the lower half of an active pair and the upper sprite
    // must come strictly first: the two trade places.
    assign o_swap_up = i_ctl.sort && (i_odd == i_ctl.phase) && r_valid && i_up_valid
                       && goes_before(i_ctl.mode, i_up_entry, r_entry);

    // Next content of the slot.
    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        priority if (i_ctl.shift) begin
            n_valid = i_up_valid;
            n_entry = i_up_entry;
        end else if (o_swap_up) begin
            n_entry = i_up_entry;
        end else if (i_dn_swap) begin
            n_entry = i_dn_entry;
        end else begin
            n_entry = r_entry;
        end
    end

    // Valid bit is control state; the payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_valid = r_valid;
    assign o_entry = r_entry;

endmodule

// ===== design/ssb_out.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ssb_out
// Result formatter: turns the sprite leaving the bottom of the chain into a
// result beat with vertex offset, batch start and batch vertex count.
// ============================================================================
module ssb_out
    import ssb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_emit_ctl        i_ctl,
    input  logic             i_cur_valid,
    input  t_entry           i_cur,
    input  logic             i_next_valid,
    input  logic [TEX_W-1:0] i_next_tex,
    output logic             o_strobe,
    output t_result          o_result
);

    logic             r_seen;
    logic [TEX_W-1:0] r_prev_tex;
    logic [VTX_W-1:0] r_offset;
    logic [VTX_W-1:0] r_run_verts;
    logic             r_strobe;
    t_result          r_result;

    logic             w_fire;
    logic             w_start;
    logic             w_final;
    logic [VTX_W-1:0] w_run_verts;

    // Batch boundaries: first sprite, or a change of texture on either side.
    assign w_fire      = i_ctl.active && i_cur_valid;
    assign w_start     = !r_seen || (i_cur.texture != r_prev_tex);
    assign w_final     = !i_next_valid || (i_next_tex != i_cur.texture);
    assign w_run_verts = w_start ? VERTS_PER_GLYPH : VTX_W'(r_run_verts + VERTS_PER_GLYPH);

    // Running counters, cleared between loads.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_fire;
            if (!i_ctl.active) begin
                r_seen <= 1'b0;
            end else if (w_fire) begin
                r_seen <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_ctl.active) begin
            r_offset <= '0;
        end else if (w_fire) begin
            r_offset    <= VTX_W'(r_offset + VERTS_PER_GLYPH);
            r_run_verts <= w_run_verts;
            r_prev_tex  <= i_cur.texture;
        end
    end

    // Registered result beat.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_result.sprite_index       <= i_cur.index;
            r_result.texture_out        <= i_cur.texture;
            r_result.vertex_offset      <= r_offset;
            r_result.batch_start        <= w_start;
            r_result.batch_vertex_count <= w_final ? w_run_verts : '0;
            r_result.overflow           <= i_ctl.overflow;
            r_result.last_result        <= !i_next_valid;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== design/sprite_sort_batcher_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sprite_sort_batcher_core
// Loads a list of sprites into a chain of cells, stable-sorts them by depth
// or texture, and emits them in order with texture batch information.
// ============================================================================
//
// Channel   Signals                          Handshake
// --------  -------------------------------  ------------------------------
// sprite    i_start, o_busy, i_sprite        beat taken when i_start & !o_busy
// result    o_strobe, o_result               one strobe per beat, no stall
// config    i_cfg_valid, o_cfg_ready,        beat taken when valid & ready
//           i_cfg_data
//
// A sprite that is not marked last leaves o_busy low, so loading runs at
// one beat per cycle. The beat marked last starts the odd-even rounds in
// the cell chain, then shifting out of the bottom cell; the n results
// come at the end of the shifting, one per cycle, each registered as it
// leaves the chain. o_busy stays high from the last sprite until the final
// result leaves the chain. Reset is synchronous and empties the chain; the
// sort mode returns to texture order.
// ============================================================================
module sprite_sort_batcher_core
    import ssb_pkg::*;
#(
    parameter int MAX_GLYPHS = MAX_GLYPHS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  t_sprite           i_sprite,
    output logic              o_strobe,
    output t_result           o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [MODE_W-1:0] i_cfg_data
);

    localparam int ROUNDS  = MAX_GLYPHS + 1;
    localparam int CNT_W   = $clog2(MAX_GLYPHS + 1);
    localparam int ROUND_W = $clog2(ROUNDS);

    t_state             r_state;
    t_state             n_state;
    logic [MODE_W-1:0]  r_mode;
    logic [CNT_W-1:0]   r_count;
    logic               r_overflow;
    logic [ROUND_W-1:0] r_round;

    logic      w_busy;
    logic      w_accept;
    logic      w_room;
    logic      w_sorting;
    logic      w_emitting;
    logic      w_done;
    t_cell_ctl w_ctl;
    t_emit_ctl w_emit;
    t_entry    w_in_entry;
    logic      w_in_valid;

    logic   w_valid [MAX_GLYPHS];
    t_entry w_entry [MAX_GLYPHS];
    logic   w_swap  [MAX_GLYPHS];

    // Input acceptance and capacity.
    assign w_accept = i_start && !w_busy;
    assign w_room   = r_count < CNT_W'(MAX_GLYPHS);
    assign w_done   = w_valid[0] && !w_valid[1];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept && i_sprite.last_sprite) begin
                n_state = S_SORT;
            end
            S_SORT: if (r_round == ROUND_W'(ROUNDS - 1)) begin
                n_state = S_EMIT;
            end
            S_EMIT: if (w_done) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        w_busy     = 1'b1;
        w_sorting  = 1'b0;
        w_emitting = 1'b0;
        unique case (r_state)
            S_IDLE:  w_busy     = 1'b0;
            S_SORT:  w_sorting  = 1'b1;
            S_EMIT:  w_emitting = 1'b1;
            default: w_busy     = 1'b1;
        endcase
    end

    // Sequencer, fill count and overflow flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mode     <= MODE_RESET;
            r_count    <= '0;
            r_overflow <= 1'b0;
            r_round    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_data;
            end
            if (w_accept && w_room) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (w_emitting && w_done) begin
                r_count <= '0;
            end
            if (w_accept && !w_room) begin
                r_overflow <= 1'b1;
            end else if (w_emitting && w_done) begin
                r_overflow <= 1'b0;
            end
            r_round <= w_sorting ? ROUND_W'(r_round + 1'b1) : '0;
        end
    end

    // New sprite enters at the top of the chain.
    assign w_in_valid         = w_accept && w_room;
    assign w_in_entry.texture = i_sprite.texture_id;
    assign w_in_entry.depth   = i_sprite.depth_bits;
    assign w_in_entry.index   = IDX_W'(r_count);

    assign w_ctl.shift = w_in_valid || w_emitting;
    assign w_ctl.sort  = w_sorting;
    assign w_ctl.phase = r_round[0];
    assign w_ctl.mode  = r_mode;

    // Chain of cells; index 0 is the bottom, where results leave.
    for (genvar g = 0; g < MAX_GLYPHS; g++) begin : g_cell
        logic   w_up_valid;
        t_entry w_up_entry;
        logic   w_dn_swap;
        t_entry w_dn_entry;

        if (g == MAX_GLYPHS - 1) begin : g_top
            assign w_up_valid = w_in_valid;
            assign w_up_entry = w_in_entry;
        end else begin : g_mid
            assign w_up_valid = w_valid[g+1];
            assign w_up_entry = w_entry[g+1];
        end

        if (g == 0) begin : g_bottom
            assign w_dn_swap  = 1'b0;
            assign w_dn_entry = w_in_entry;
        end else begin : g_upper
            assign w_dn_swap  = w_swap[g-1];
            assign w_dn_entry = w_entry[g-1];
        end

        ssb_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_odd      (1'(g % 2)),
            .i_up_valid (w_up_valid),
            .i_up_entry (w_up_entry),
            .i_dn_swap  (w_dn_swap),
            .i_dn_entry (w_dn_entry),
            .o_valid    (w_valid[g]),
            .o_entry    (w_entry[g]),
            .o_swap_up  (w_swap[g])
        );
    end

    // Result formatting from the bottom two cells.
    assign w_emit.active   = w_emitting;
    assign w_emit.overflow = r_overflow;

    ssb_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_emit),
        .i_cur_valid  (w_valid[0]),
        .i_cur        (w_entry[0]),
        .i_next_valid (w_valid[1]),
        .i_next_tex   (w_entry[1].texture),
        .o_strobe     (o_strobe),
        .o_result     (o_result)
    );

    assign o_busy      = w_busy;
    assign o_cfg_ready = !w_busy;

`ifndef SYNTH
    // A result beat only follows a cycle of emitting.
    a_strobe_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_EMIT))
        else $error("result beat outside emit phase");

    // The fill count never passes capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_GLYPHS))
        else $error("fill count beyond capacity");

    // Sorting only exchanges entries and never changes occupancy.
    a_sort_keeps_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SORT) |=> (w_valid[0] == $past(w_valid[0]))
                                && (w_valid[MAX_GLYPHS-1] == $past(w_valid[MAX_GLYPHS-1])))
        else $error("occupancy changed during sort");

    // Leaving the emit phase shows the final result of the run.
    a_last_on_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_done) |=> (o_strobe && o_result.last_result))
        else $error("emit ended without the final result");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the sprite sort batcher core. Sprite loads are sent
// through the start/busy port, and a scoreboard predicts the sorted result
// beats of each load. Every strobed result is then compared with them field
// by field. The run covers all sort modes, ties, special depth values, a full
// single-texture load and a load that overflows capacity. The sender idles
// at random, and mode writes happen only while the core is idle.
// ============================================================================
module testbench
    import ssb_pkg::*;
;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 8;
    localparam int SLOTS         = MAX_GLYPHS_DEF;
    localparam int TOTAL_SPRITES = 410;
    localparam int CALM_TAIL     = 60;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 20;
    localparam int STALL_LIMIT   = 2000;
    localparam int REPORT_MAX    = 10;

    // Predicts the sorted result beats of each sprite load and checks them.
    class sort_scoreboard;
        logic [TEX_W-1:0]   tex_mem [SLOTS];
        logic [DEPTH_W-1:0] depth_mem [SLOTS];
        int                 stored;
        bit                 dropped;
        logic [MODE_W-1:0]  mode;
        t_result            batch_q [$];
        int                 errors;
        int                 checked;

        function new();
            stored  = 0;
            dropped = 0;
            mode    = MODE_RESET;
            errors  = 0;
            checked = 0;
        endfunction

        function void set_mode(logic [MODE_W-1:0] m);
            mode = m;
        endfunction

        function int pending();
            return batch_q.size();
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= REPORT_MAX) begin
                $display("mismatch: %s", msg);
            end
        endfunction

        // Map raw single-precision bits onto an unsigned total order.
        function logic [DEPTH_W-1:0] depth_rank(logic [DEPTH_W-1:0] bits);
            return bits[DEPTH_W-1] ? ~bits : {1'b1, bits[DEPTH_W-2:0]};
        endfunction

        // Store one accepted sprite; on the last one, sort and queue the beats.
        function void note_sprite(t_sprite s);
            logic [IDX_W-1:0] order [SLOTS];
            logic [IDX_W-1:0] cur;
            logic [TEX_W-1:0] t;
            t_result          r;
            bit               moves;
            bit               batch_end;
            int               n;
            int               j;
            int               run_start;
            if (stored < SLOTS) begin
                tex_mem[stored]   = s.texture_id;
                depth_mem[stored] = s.depth_bits;
                stored++;
            end else begin
                dropped = 1'b1;
            end
            if (!s.last_sprite) begin
                return;
            end
            n = stored;

            // Stable insertion sort: a sprite only moves past strictly worse keys.
            for (int i = 0; i < n; i++) begin
                cur = IDX_W'(i);
                j = i;
                while (j > 0) begin
                    case (mode)
                        MODE_DEPTH_DESC: moves = depth_rank(depth_mem[cur]) >
                                                 depth_rank(depth_mem[order[j-1]]);
                        MODE_DEPTH_ASC:  moves = depth_rank(depth_mem[cur]) <
                                                 depth_rank(depth_mem[order[j-1]]);
                        MODE_TEXTURE:    moves = tex_mem[cur] < tex_mem[order[j-1]];
                        default:         moves = 1'b0;
                    endcase
                    if (!moves) begin
                        break;
                    end
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = cur;
            end

            // Walk the sorted list and mark texture batches.
            run_start = 0;
            for (int i = 0; i < n; i++) begin
                t = tex_mem[order[i]];
                r.batch_start = (i == 0) || (t != tex_mem[order[i-1]]);
                if (r.batch_start) begin
                    run_start = i;
                end
                batch_end            = (i + 1 == n) || (tex_mem[order[i+1]] != t);
                r.sprite_index       = order[i];
                r.texture_out        = t;
                r.vertex_offset      = VTX_W'(i) * VERTS_PER_GLYPH;
                r.batch_vertex_count = batch_end ?
                                       VTX_W'(i + 1 - run_start) * VERTS_PER_GLYPH : '0;
                r.overflow           = dropped;
                r.last_result        = (i + 1 == n);
                batch_q.push_back(r);
            end
            stored  = 0;
            dropped = 0;
        endfunction

        // Compare one result beat with the oldest expected beat.
        function void check_result(t_result got);
            t_result want;
            if (batch_q.size() == 0) begin
                note_error($sformatf("result beat with nothing expected, index %0d texture %0h",
                                     got.sprite_index, got.texture_out));
                return;
            end
            want = batch_q.pop_front();
            if (got.sprite_index !== want.sprite_index)
                note_error($sformatf("beat %0d sprite_index: expected %0d, got %0d",
                                     checked, want.sprite_index, got.sprite_index));
            if (got.texture_out !== want.texture_out)
                note_error($sformatf("beat %0d texture_out: expected %0h, got %0h",
                                     checked, want.texture_out, got.texture_out));
            if (got.vertex_offset !== want.vertex_offset)
                note_error($sformatf("beat %0d vertex_offset: expected %0d, got %0d",
                                     checked, want.vertex_offset, got.vertex_offset));
            if (got.batch_start !== want.batch_start)
                note_error($sformatf("beat %0d batch_start: expected %0b, got %0b",
                                     checked, want.batch_start, got.batch_start));
            if (got.batch_vertex_count !== want.batch_vertex_count)
                note_error($sformatf("beat %0d batch_vertex_count: expected %0d, got %0d",
                                     checked, want.batch_vertex_count,
                                     got.batch_vertex_count));
            if (got.overflow !== want.overflow)
                note_error($sformatf("beat %0d overflow: expected %0b, got %0b",
                                     checked, want.overflow, got.overflow));
            if (got.last_result !== want.last_result)
                note_error($sformatf("beat %0d last_result: expected %0b, got %0b",
                                     checked, want.last_result, got.last_result));
            checked++;
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_start = 1'b0;
    logic              o_busy;
    t_sprite           i_sprite = '0;
    logic              o_strobe;
    t_result           o_result;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [MODE_W-1:0] i_cfg_data = MODE_RESET;

    sort_scoreboard sb = new();
    int             sprites_sent = 0;
    int             loads_seen = 0;
    int             stall_cycles = 0;
    t_sprite        corner_set [5];

    sprite_sort_batcher_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_sprite    (i_sprite),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Free-running clock.
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Observe every handshake at the edge and run the stall watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                sb.note_sprite(i_sprite);
                if (i_sprite.last_sprite) begin
                    loads_seen++;
                end
            end
            if (o_strobe) begin
                sb.check_result(o_result);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.set_mode(i_cfg_data);
            end
            if ((i_start && !o_busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles + 1 >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
                $display("testbench: done, errors");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Offer one sprite and hold it until the core takes it.
    task automatic send_sprite(t_sprite s);
        i_start  <= 1'b1;
        i_sprite <= s;
        do begin
            @(posedge i_clk);
        end while (o_busy);
        sprites_sent++;
    endtask

    task automatic idle_sender(int cycles);
        i_start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Pause until every expected beat has come and the core has settled.
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(logic [MODE_W-1:0] m);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // One load of random sprites; one_texture gives a single batch.
    task automatic send_load(int count, bit one_texture, bit calm);
        t_sprite          s;
        logic [TEX_W-1:0] shared_tex;
        shared_tex = $urandom;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 3))
                0:       s.texture_id = $urandom;
                1:       s.texture_id = $urandom_range(0, 1) ? '1 : '0;
                default: s.texture_id = TEX_W'($urandom_range(0, 3));
            endcase
            if (one_texture) begin
                s.texture_id = shared_tex;
            end
            case ($urandom_range(0, 3))
                0: s.depth_bits = $urandom;
                1: begin
                    case ($urandom_range(0, 5))
                        0:       s.depth_bits = 32'h0000_0000;
                        1:       s.depth_bits = 32'h8000_0000;
                        2:       s.depth_bits = 32'h7F80_0000;
                        3:       s.depth_bits = 32'hFF80_0000;
                        4:       s.depth_bits = 32'h7FC0_0000;
                        default: s.depth_bits = 32'hFFFF_FFFF;
                    endcase
                end
                // Few distinct values of both signs, so depth ties are common.
                default: s.depth_bits = {1'($urandom_range(0, 1)), 8'h3F,
                                         23'($urandom_range(0, 3))};
            endcase
            s.last_sprite = (k == count - 1);
            if (!calm && sprites_sent < TOTAL_SPRITES - CALM_TAIL
                    && $urandom_range(0, 3) == 0) begin
                idle_sender($urandom_range(1, 7));
            end
            send_sprite(s);
        end
    endtask

    // Signed zeros, infinities, a NaN and extreme textures in one load.
    task automatic send_corner_set();
        foreach (corner_set[k]) begin
            send_sprite(corner_set[k]);
        end
    endtask

    initial begin
        int                phase;
        int                loads;
        int                size;
        bit                calm;
        logic [MODE_W-1:0] mode;
        t_sprite           lone;

        corner_set[0] = '{texture_id: '1, depth_bits: 32'h0000_0000, last_sprite: 1'b0};
        corner_set[1] = '{texture_id: '0, depth_bits: 32'h8000_0000, last_sprite: 1'b0};
        corner_set[2] = '{texture_id: '1, depth_bits: 32'h7F80_0000, last_sprite: 1'b0};
        corner_set[3] = '{texture_id: 32'd5, depth_bits: 32'hFF80_0000, last_sprite: 1'b0};
        corner_set[4] = '{texture_id: 32'd5, depth_bits: 32'h7FC0_0000, last_sprite: 1'b1};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: the corner load in the reset mode and every other mode.
        send_corner_set();
        drain();
        write_mode(MODE_DEPTH_DESC);
        send_corner_set();
        drain();
        write_mode(MODE_DEPTH_ASC);
        send_corner_set();
        drain();
        write_mode(MODE_UNUSED);
        send_corner_set();
        lone = '{texture_id: 32'h8000_0001, depth_bits: '1, last_sprite: 1'b1};
        send_sprite(lone);
        drain();

        // Random phases: a mode write, then several loads back to back.
        phase = 0;
        while (sprites_sent < TOTAL_SPRITES) begin
            case (phase)
                0:       mode = MODE_DEPTH_DESC;
                1:       mode = MODE_TEXTURE;
                2:       mode = MODE_DEPTH_ASC;
                default: mode = MODE_W'($urandom_range(0, 2));
            endcase
            write_mode(mode);
            calm  = (phase % 3 == 2);
            loads = $urandom_range(2, 5);
            for (int l = 0; l < loads; l++) begin
                // A full single-texture load, then a load that runs past capacity.
                if (phase == 1 && l == 0) begin
                    send_load(SLOTS, 1'b1, calm);
                end else if (phase == 3 && l == 0) begin
                    send_load(SLOTS + 2, 1'b0, calm);
                end else begin
                    size = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24)
                                                        : $urandom_range(1, 12);
                    send_load(size, 1'b0, calm);
                end
            end
            drain();
            phase++;
        end

        repeat (END_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.note_error($sformatf("%0d expected beats never arrived", sb.pending()));
        end
        $display("summary: %0d sprites in %0d loads over %0d mode phases",
                 sprites_sent, loads_seen, phase);
        $display("summary: %0d result beats checked, %0d mismatches",
                 sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
